### hdl/tpmc_pkg.sv
// shared types, codes and calibration constants for the thruster pair mixer
`timescale 1ns / 1ps
`default_nettype none

package tpmc_pkg;

	localparam int CMD_W      = 2;
	localparam int SPEED_W    = 16;
	localparam int OFFSET_W   = 16;
	localparam int DUTY_W     = 8;
	localparam int MAG_W      = SPEED_W + 1;
	localparam int REG_IDX_W  = 3;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 24;

	localparam int LEVEL_FLOOR = 147;
	localparam int LEVEL_CEIL  = 255;

	// reciprocal scaling for the exact quotient of the in-range remainder
	localparam int RECIP_SHIFT = 33;
	localparam int CD_W    = 14;
	localparam int DIV_W   = 13;
	localparam int RECIP_W = 21;
	localparam int LO_W    = 20;
	localparam int HI_W    = 21;
	localparam int REM_W   = 20;
	localparam int NUM_W   = 30;

	typedef enum logic [CMD_W-1:0] {
		CMD_SURGE = 2'd0,
		CMD_SWAY  = 2'd1,
		CMD_HEAVE = 2'd2,
		CMD_TURN  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		PAIR_SURGE = 2'd0,
		PAIR_SWAY  = 2'd1,
		PAIR_HEAVE = 2'd2
	} pair_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_OFFSET_EAST        = 3'd0,
		REG_OFFSET_SOUTH_HEAVE = 3'd1,
		REG_OFFSET_NORTH_SWAY  = 3'd2,
		REG_OFFSET_NORTH_HEAVE = 3'd3,
		REG_OFFSET_SOUTH_SWAY  = 3'd4
	} reg_idx_t;

	// cd: intercept minus 397.65 in hundredths, d: 16 * |slope| in hundredths,
	// recip: ceil(2^33 / d), lo/hi: numerator bounds for levels 147 and 256
	typedef struct packed {
		logic [CD_W-1:0]    cd;
		logic [DIV_W-1:0]   d;
		logic [RECIP_W-1:0] recip;
		logic [LO_W-1:0]    lo;
		logic [HI_W-1:0]    hi;
	} cal_t;

	localparam longint CD_EAST   = 50622 - 39765;
	localparam longint CD_NSWAY  = 53985 - 39765;
	localparam longint CD_SSWAY  = 54739 - 39765;
	localparam longint CD_NHEAVE = 44132 - 39765;
	localparam longint CD_SHEAVE = 44862 - 39765;

	localparam longint D_EAST   = 16 * 265;
	localparam longint D_NSWAY  = 16 * 338;
	localparam longint D_SSWAY  = 16 * 293;
	localparam longint D_NHEAVE = 16 * 303;
	localparam longint D_SHEAVE = 16 * 292;

	localparam longint R_EAST   = ((64'sd1 <<< RECIP_SHIFT) + D_EAST - 1) / D_EAST;
	localparam longint R_NSWAY  = ((64'sd1 <<< RECIP_SHIFT) + D_NSWAY - 1) / D_NSWAY;
	localparam longint R_SSWAY  = ((64'sd1 <<< RECIP_SHIFT) + D_SSWAY - 1) / D_SSWAY;
	localparam longint R_NHEAVE = ((64'sd1 <<< RECIP_SHIFT) + D_NHEAVE - 1) / D_NHEAVE;
	localparam longint R_SHEAVE = ((64'sd1 <<< RECIP_SHIFT) + D_SHEAVE - 1) / D_SHEAVE;

	localparam cal_t CAL_EAST = '{
		cd: CD_W'(CD_EAST), d: DIV_W'(D_EAST), recip: RECIP_W'(R_EAST),
		lo: LO_W'(LEVEL_FLOOR * D_EAST), hi: HI_W'((LEVEL_CEIL + 1) * D_EAST)};
	localparam cal_t CAL_NSWAY = '{
		cd: CD_W'(CD_NSWAY), d: DIV_W'(D_NSWAY), recip: RECIP_W'(R_NSWAY),
		lo: LO_W'(LEVEL_FLOOR * D_NSWAY), hi: HI_W'((LEVEL_CEIL + 1) * D_NSWAY)};
	localparam cal_t CAL_SSWAY = '{
		cd: CD_W'(CD_SSWAY), d: DIV_W'(D_SSWAY), recip: RECIP_W'(R_SSWAY),
		lo: LO_W'(LEVEL_FLOOR * D_SSWAY), hi: HI_W'((LEVEL_CEIL + 1) * D_SSWAY)};
	localparam cal_t CAL_NHEAVE = '{
		cd: CD_W'(CD_NHEAVE), d: DIV_W'(D_NHEAVE), recip: RECIP_W'(R_NHEAVE),
		lo: LO_W'(LEVEL_FLOOR * D_NHEAVE), hi: HI_W'((LEVEL_CEIL + 1) * D_NHEAVE)};
	localparam cal_t CAL_SHEAVE = '{
		cd: CD_W'(CD_SHEAVE), d: DIV_W'(D_SHEAVE), recip: RECIP_W'(R_SHEAVE),
		lo: LO_W'(LEVEL_FLOOR * D_SHEAVE), hi: HI_W'((LEVEL_CEIL + 1) * D_SHEAVE)};

	// clamped level of a calibrated thruster: n = 16*(271*m + cd) - 100*k,
	// level = trunc(n / d), forced to 0 below 147 and 255 above 255
	function automatic logic [DUTY_W-1:0] calib_level(
		input cal_t c,
		input logic [MAG_W-1:0] mag,
		input logic signed [OFFSET_W-1:0] off
	);
		logic [24:0] m271;
		logic [24:0] base;
		logic signed [NUM_W-1:0] k;
		logic signed [NUM_W-1:0] k100;
		logic signed [NUM_W-1:0] b16;
		logic signed [NUM_W-1:0] n;
		logic signed [NUM_W-1:0] lo_s;
		logic signed [NUM_W-1:0] hi_s;
		logic [REM_W-1:0] r;
		logic [REM_W+RECIP_W-1:0] prod;
		logic [DUTY_W-1:0] lvl;
		m271 = (25'(mag) << 8) + (25'(mag) << 4) - 25'(mag);
		base = m271 + 25'(c.cd);
		k    = NUM_W'(off);
		k100 = (k <<< 6) + (k <<< 5) + (k <<< 2);
		b16  = signed'({1'b0, base, 4'b0000});
		n    = b16 - k100;
		lo_s = signed'(NUM_W'(c.lo));
		hi_s = signed'(NUM_W'(c.hi));
		r    = REM_W'(n - lo_s);
		prod = (REM_W+RECIP_W)'(r) * (REM_W+RECIP_W)'(c.recip);
		if (n < lo_s) begin
			lvl = '0;
		end else if (n >= hi_s) begin
			lvl = DUTY_W'(LEVEL_CEIL);
		end else begin
			lvl = DUTY_W'(LEVEL_FLOOR) + DUTY_W'(prod[RECIP_SHIFT+6:RECIP_SHIFT]);
		end
		return lvl;
	endfunction

	// reference thruster: the magnitude itself with the same clamp
	function automatic logic [DUTY_W-1:0] plain_level(input logic [MAG_W-1:0] mag);
		logic [DUTY_W-1:0] lvl;
		if (mag < MAG_W'(LEVEL_FLOOR)) begin
			lvl = '0;
		end else if (mag > MAG_W'(LEVEL_CEIL)) begin
			lvl = DUTY_W'(LEVEL_CEIL);
		end else begin
			lvl = mag[DUTY_W-1:0];
		end
		return lvl;
	endfunction

endpackage

`default_nettype wire

### hdl/thruster_pair_mixer_calibrated_core.sv
// top level of the thruster pair mixer: command decode, calibration and output register
//
// usage
//   s_* channel takes one command item: cmd and signed speed packed in s_tdata
//   m_* channel gives one result item per command: pair, inverted duties, directions
//   cfg_we / cfg_index / cfg_data write the five signed Q11.4 calibration offsets;
//   write them only while no item is in flight, indexes above four are ignored
// timing
//   an accepted item lands in the input register, the calibration of both thrusters
//   runs in the one combinational stage behind it, and the result is registered
//   at the next edge: m_tvalid rises one cycle after the accepting edge
//   one item per cycle sustained; the two registers pass items on as long as
//   the output side takes them
// reset
//   arst_n clears both valid flags, all offsets and the surge/sway memory for turn
// stall
//   with m_tready low the result holds; the input register still takes one more
//   item, then s_tready drops until the output frees up
`timescale 1ns / 1ps
`default_nettype none

module thruster_pair_mixer_calibrated_core (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// command item: [1:0] cmd, [17:2] speed, [23:18] zero
	input  wire logic [tpmc_pkg::IN_TDATA_W-1:0]   s_tdata,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// result item: [1:0] pair, [9:2] duty_first, [10] dir_first,
	// [18:11] duty_second, [19] dir_second, [23:20] zero
	output logic [tpmc_pkg::OUT_TDATA_W-1:0]       m_tdata,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	input  wire logic                              cfg_we,
	input  wire logic [tpmc_pkg::REG_IDX_W-1:0]    cfg_index,
	input  wire logic [tpmc_pkg::OFFSET_W-1:0]     cfg_data
);
	import tpmc_pkg::*;

	// calibration offsets
	logic signed [OFFSET_W-1:0] off_east_q;
	logic signed [OFFSET_W-1:0] off_south_heave_q;
	logic signed [OFFSET_W-1:0] off_north_sway_q;
	logic signed [OFFSET_W-1:0] off_north_heave_q;
	logic signed [OFFSET_W-1:0] off_south_sway_q;

	// set by surge, cleared by sway; picks the pair a turn steers
	logic last_surge_q;

	// input register
	logic                      valid_s1;
	cmd_t                      cmd_s1;
	logic signed [SPEED_W-1:0] speed_s1;
	logic                      turn_surge_s1;

	// output register
	logic                      valid_q;
	logic [OUT_TDATA_W-1:0]    data_q;

	logic in_accept;
	logic out_free;
	logic move_s1;

	cmd_t                      in_cmd;
	logic signed [SPEED_W-1:0] in_speed;

	logic [MAG_W-1:0]          mag;
	logic                      pos;
	pair_t                     pair;
	logic                      dir_first;
	logic                      dir_second;
	cal_t                      cal_first;
	cal_t                      cal_second;
	logic signed [OFFSET_W-1:0] off_first;
	logic signed [OFFSET_W-1:0] off_second;
	logic [DUTY_W-1:0]         lvl_first;
	logic [DUTY_W-1:0]         lvl_second;
	logic [DUTY_W-1:0]         duty_first;
	logic [DUTY_W-1:0]         duty_second;

	assign in_cmd   = cmd_t'(s_tdata[CMD_W-1:0]);
	assign in_speed = signed'(s_tdata[CMD_W+SPEED_W-1:CMD_W]);

	// handshakes: the output register frees when empty or being taken
	assign out_free  = !valid_q || m_tready;
	assign move_s1   = valid_s1 && out_free;
	assign s_tready  = !valid_s1 || out_free;
	assign in_accept = s_tvalid && s_tready;

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_east_q        <= '0;
			off_south_heave_q <= '0;
			off_north_sway_q  <= '0;
			off_north_heave_q <= '0;
			off_south_sway_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_OFFSET_EAST:        off_east_q        <= signed'(cfg_data);
				REG_OFFSET_SOUTH_HEAVE: off_south_heave_q <= signed'(cfg_data);
				REG_OFFSET_NORTH_SWAY:  off_north_sway_q  <= signed'(cfg_data);
				REG_OFFSET_NORTH_HEAVE: off_north_heave_q <= signed'(cfg_data);
				REG_OFFSET_SOUTH_SWAY:  off_south_sway_q  <= signed'(cfg_data);
				default: begin
				end
			endcase
		end
	end

	// turn memory, updated in item order at accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_surge_q <= 1'b0;
		end else if (in_accept) begin
			if (in_cmd == CMD_SURGE) begin
				last_surge_q <= 1'b1;
			end else if (in_cmd == CMD_SWAY) begin
				last_surge_q <= 1'b0;
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_s1        <= in_cmd;
			speed_s1      <= in_speed;
			turn_surge_s1 <= last_surge_q;
		end
	end

	// pair, direction and calibration selection
	always_comb begin
		pos = (speed_s1 > 0);
		mag = speed_s1[SPEED_W-1] ? (MAG_W'(0) - MAG_W'(speed_s1)) : MAG_W'(speed_s1);
		case (cmd_s1)
			CMD_SURGE: begin
				pair       = PAIR_SURGE;
				dir_first  = pos;
				dir_second = pos;
			end
			CMD_SWAY: begin
				pair       = PAIR_SWAY;
				dir_first  = pos;
				dir_second = pos;
			end
			CMD_HEAVE: begin
				pair       = PAIR_HEAVE;
				dir_first  = pos;
				dir_second = pos;
			end
			CMD_TURN: begin
				// turn spins the pair other than the one the last surge or sway command used
				if (turn_surge_s1) begin
					pair       = PAIR_SWAY;
					dir_first  = !pos;
					dir_second = pos;
				end else begin
					pair       = PAIR_SURGE;
					dir_first  = pos;
					dir_second = !pos;
				end
			end
			default: begin
				pair       = PAIR_SURGE;
				dir_first  = pos;
				dir_second = pos;
			end
		endcase

		case (pair)
			PAIR_SWAY: begin
				cal_first  = CAL_NSWAY;
				off_first  = off_north_sway_q;
				cal_second = CAL_SSWAY;
				off_second = off_south_sway_q;
			end
			PAIR_HEAVE: begin
				cal_first  = CAL_NHEAVE;
				off_first  = off_north_heave_q;
				cal_second = CAL_SHEAVE;
				off_second = off_south_heave_q;
			end
			default: begin
				// surge pair: east calibrated, west is the reference
				cal_first  = CAL_EAST;
				off_first  = off_east_q;
				cal_second = CAL_SSWAY;
				off_second = off_south_sway_q;
			end
		endcase

		lvl_first = calib_level(cal_first, mag, off_first);
		if (pair == PAIR_SURGE) begin
			lvl_second = plain_level(mag);
		end else begin
			lvl_second = calib_level(cal_second, mag, off_second);
		end

		// thruster drive is active low: duty is 255 minus level
		duty_first  = DUTY_W'(LEVEL_CEIL) - lvl_first;
		duty_second = DUTY_W'(LEVEL_CEIL) - lvl_second;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			data_q <= {4'b0000, dir_second, duty_second, dir_first, duty_first, pair};
		end
	end

	// checks

	// an item in the input register with room ahead shows up at the output
	assert property (@(posedge clk) disable iff (!arst_n)
		move_s1 |=> m_tvalid)
		else $error("input register item did not reach the output");

	// surge command arms the turn memory
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && in_cmd == CMD_SURGE) |=> last_surge_q)
		else $error("surge did not set the turn memory");

	// sway command clears the turn memory
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && in_cmd == CMD_SWAY) |=> !last_surge_q)
		else $error("sway did not clear the turn memory");

	// no pair code beyond heave
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[1:0] != 2'b11))
		else $error("result carries an unused pair code");

	// levels are either off or at least the floor, so duties avoid the gap
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[9:2] == 8'd255 || m_tdata[9:2] <= 8'd108)
			&& (m_tdata[18:11] == 8'd255 || m_tdata[18:11] <= 8'd108)))
		else $error("duty inside the dead band");

endmodule

`default_nettype wire

### verif/tb.sv
// self-checking stream testbench for the calibrated thruster pair mixer
`timescale 1ns / 1ps

module tb;
	import tpmc_pkg::*;

	localparam int HOLD_CYCLES   = 300;
	localparam int STALL_LIMIT   = 4000;
	localparam int PHASE_ITEMS   = 250;
	localparam int MAX_REPORTS   = 10;
	localparam logic [REG_IDX_W-1:0] REG_IDX_UNUSED_LO = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_IDX_UNUSED_HI = 3'd7;

	typedef struct packed {
		cmd_t               cmd;
		logic signed [15:0] speed;
	} order_t;

	typedef struct packed {
		pair_t      pair;
		logic [7:0] duty_first;
		logic       dir_first;
		logic [7:0] duty_second;
		logic       dir_second;
	} mix_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [REG_IDX_W-1:0]   cfg_index = '0;
	logic [OFFSET_W-1:0]    cfg_data = '0;

	thruster_pair_mixer_calibrated_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// local copy of the calibration offsets and of the surge/sway memory
	logic signed [15:0] off_east = '0;
	logic signed [15:0] off_south_heave = '0;
	logic signed [15:0] off_north_sway = '0;
	logic signed [15:0] off_north_heave = '0;
	logic signed [15:0] off_south_sway = '0;
	logic               surge_mem = 1'b0;

	order_t cmd_backlog[$];
	mix_t   pending_mixes[$];

	int  sent_cnt = 0;
	int  taken_cnt = 0;
	int  result_cnt = 0;
	int  errors = 0;
	int  mismatches = 0;
	int  stall_cycles = 0;
	int  cmd_seen[4] = '{0, 0, 0, 0};
	int  hold_req = 0;
	int  hold_done = 0;
	int  hold_left = 0;
	int  cfg_writes = 0;
	bit  idle_on = 1'b1;

	function automatic logic [7:0] clamp_thrust(longint lv);
		if (lv < LEVEL_FLOOR)
			return 8'd0;
		if (lv > LEVEL_CEIL)
			return 8'(LEVEL_CEIL);
		return 8'(lv);
	endfunction

	// linear calibration: trunc((2.71*m + c - 397.65 - k/16) / s), all in hundredths
	function automatic logic [7:0] thrust_level(longint mag, longint c100, longint s100,
			logic signed [15:0] off);
		longint a;
		a = 16 * (39765 - c100 - 271 * mag) + 100 * longint'(off);
		return clamp_thrust((-a) / (16 * s100));
	endfunction

	function automatic mix_t mix_thrusters(cmd_t cmd, logic signed [15:0] spd);
		mix_t       r;
		longint     mag;
		logic       pos;
		logic [7:0] east_lv, west_lv, nsway_lv, ssway_lv, l1, l2;
		mag      = (spd < 0) ? -longint'(spd) : longint'(spd);
		pos      = (spd > 0);
		east_lv  = thrust_level(mag, 50622, 265, off_east);
		west_lv  = clamp_thrust(mag);
		nsway_lv = thrust_level(mag, 53985, 338, off_north_sway);
		ssway_lv = thrust_level(mag, 54739, 293, off_south_sway);
		case (cmd)
			CMD_SURGE: begin
				r.pair = PAIR_SURGE; l1 = east_lv; l2 = west_lv;
				r.dir_first = pos; r.dir_second = pos;
				surge_mem = 1'b1;
			end
			CMD_SWAY: begin
				r.pair = PAIR_SWAY; l1 = nsway_lv; l2 = ssway_lv;
				r.dir_first = pos; r.dir_second = pos;
				surge_mem = 1'b0;
			end
			CMD_HEAVE: begin
				r.pair = PAIR_HEAVE;
				l1 = thrust_level(mag, 44132, 303, off_north_heave);
				l2 = thrust_level(mag, 44862, 292, off_south_heave);
				r.dir_first = pos; r.dir_second = pos;
			end
			default: begin
				// turn steers the pair other than the one the last surge or sway used
				if (!surge_mem) begin
					r.pair = PAIR_SURGE; l1 = east_lv; l2 = west_lv;
					r.dir_first = pos; r.dir_second = !pos;
				end else begin
					r.pair = PAIR_SWAY; l1 = nsway_lv; l2 = ssway_lv;
					r.dir_first = !pos; r.dir_second = pos;
				end
			end
		endcase
		r.duty_first  = 8'd255 - l1;
		r.duty_second = 8'd255 - l2;
		return r;
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			errors++;
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("mismatch on result %0d, %s: expected %0d, got %0d",
					result_cnt, name, want, got);
		end
	endfunction

	// acceptance, prediction, checking and the watchdog, all on the rising edge
	always @(posedge clk) begin
		mix_t want;
		mix_t got;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				pending_mixes.push_back(mix_thrusters(cmd_t'(s_tdata[1:0]), s_tdata[17:2]));
				cmd_seen[s_tdata[1:0]]++;
				taken_cnt++;
			end
			if (m_tvalid && m_tready) begin
				got = mix_t'({m_tdata[1:0], m_tdata[9:2], m_tdata[10], m_tdata[18:11],
					m_tdata[19]});
				if (pending_mixes.size() == 0) begin
					errors++;
					$display("result item with nothing expected: %h", m_tdata);
				end else begin
					want = pending_mixes.pop_front();
					check_field("pair", want.pair, got.pair);
					check_field("duty_first", want.duty_first, got.duty_first);
					check_field("dir_first", want.dir_first, got.dir_first);
					check_field("duty_second", want.duty_second, got.duty_second);
					check_field("dir_second", want.dir_second, got.dir_second);
				end
				result_cnt++;
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
				$display("tb: errors");
				$finish;
			end
		end
	end

	// command side: a new item goes out only once the previous one was taken
	always @(negedge clk) begin
		order_t o;
		if (arst_n && sent_cnt == taken_cnt) begin
			if (cmd_backlog.size() > 0 && !(idle_on && $urandom_range(99) < 6)) begin
				o = cmd_backlog.pop_front();
				s_tdata  <= {6'd0, o.speed, o.cmd};
				s_tvalid <= 1'b1;
				sent_cnt++;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result side: random gaps plus long hold-offs on request
	always @(negedge clk) begin
		if (hold_left == 0 && hold_done < hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_done++;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= !(idle_on && $urandom_range(99) < 6);
		end
	end

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_OFFSET_EAST:        off_east = val;
			REG_OFFSET_SOUTH_HEAVE: off_south_heave = val;
			REG_OFFSET_NORTH_SWAY:  off_north_sway = val;
			REG_OFFSET_NORTH_HEAVE: off_north_heave = val;
			REG_OFFSET_SOUTH_SWAY:  off_south_sway = val;
			default: ;
		endcase
		cfg_writes++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// mode 0: every offset gets fixed, 1: small random, 2: full random
	function automatic logic [15:0] pick_offset(int mode, logic [15:0] fixed);
		if (mode == 0)
			return fixed;
		if (mode == 1)
			return 16'($urandom_range(4800) - 2400);
		return 16'($urandom);
	endfunction

	task automatic write_offsets(int mode, logic [15:0] fixed);
		write_reg(REG_OFFSET_EAST, pick_offset(mode, fixed));
		write_reg(REG_OFFSET_SOUTH_HEAVE, pick_offset(mode, fixed));
		write_reg(REG_OFFSET_NORTH_SWAY, pick_offset(mode, fixed));
		write_reg(REG_OFFSET_NORTH_HEAVE, pick_offset(mode, fixed));
		write_reg(REG_OFFSET_SOUTH_SWAY, pick_offset(mode, fixed));
		// an index past the last register must leave everything alone
		write_reg(3'($urandom_range(REG_IDX_UNUSED_HI, REG_IDX_UNUSED_LO)), 16'($urandom));
	endtask

	task automatic push_cmd(cmd_t c, int spd);
		order_t o;
		o.cmd   = c;
		o.speed = 16'(spd);
		cmd_backlog.push_back(o);
	endtask

	// most speeds have magnitudes up to 420, across both clamps; the rest span 16 bits
	task automatic push_random(int n);
		int mag;
		repeat (n) begin
			if ($urandom_range(9) < 7) begin
				mag = $urandom_range(420);
				push_cmd(cmd_t'($urandom_range(3)), $urandom_range(1) ? -mag : mag);
			end else begin
				push_cmd(cmd_t'($urandom_range(3)), $urandom);
			end
		end
	endtask

	task automatic wait_idle();
		while (cmd_backlog.size() != 0 || sent_cnt != taken_cnt || pending_mixes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(posedge clk);

		// directed: turn straight from reset, both turn memories, sign and clamp edges
		push_cmd(CMD_TURN, 160);
		push_cmd(CMD_SURGE, 200);
		push_cmd(CMD_SURGE, -32768);
		push_cmd(CMD_SURGE, 0);
		push_cmd(CMD_TURN, -180);
		push_cmd(CMD_TURN, 0);
		push_cmd(CMD_SWAY, 150);
		push_cmd(CMD_SWAY, -32767);
		push_cmd(CMD_TURN, 180);
		push_cmd(CMD_TURN, -255);
		push_cmd(CMD_HEAVE, 32767);
		push_cmd(CMD_HEAVE, -120);
		push_cmd(CMD_HEAVE, 0);
		push_cmd(CMD_SURGE, 1);
		push_cmd(CMD_SURGE, 147);
		push_cmd(CMD_SURGE, -146);
		push_cmd(CMD_SURGE, 255);
		push_cmd(CMD_SURGE, 256);
		push_cmd(CMD_SWAY, -1);
		push_cmd(CMD_HEAVE, -32768);
		wait_idle();

		// offsets at the top, then at the bottom of their range
		write_offsets(0, 16'h7fff);
		push_cmd(CMD_SURGE, 0);
		push_cmd(CMD_SWAY, -32768);
		push_random(PHASE_ITEMS);
		wait_idle();
		write_offsets(0, 16'h8000);
		push_cmd(CMD_HEAVE, 32767);
		push_random(PHASE_ITEMS);
		wait_idle();

		// back-to-back traffic on both sides
		write_offsets(1, '0);
		idle_on = 1'b0;
		push_random(PHASE_ITEMS);
		wait_idle();
		idle_on = 1'b1;

		// receiver holds off while the backlog keeps offering items
		write_offsets(1, '0);
		push_random(PHASE_ITEMS);
		hold_req++;
		wait_idle();

		// sender drains completely halfway through
		write_offsets(2, '0);
		push_random(PHASE_ITEMS / 2);
		wait_idle();
		push_random(PHASE_ITEMS / 2);
		wait_idle();

		write_offsets(1, '0);
		push_random(PHASE_ITEMS);
		wait_idle();
		write_offsets(0, '0);
		push_random(PHASE_ITEMS);
		wait_idle();
		repeat (10) @(posedge clk);

		$display("covered %0d command items (surge %0d, sway %0d, heave %0d, turn %0d)",
			taken_cnt, cmd_seen[CMD_SURGE], cmd_seen[CMD_SWAY], cmd_seen[CMD_HEAVE],
			cmd_seen[CMD_TURN]);
		$display("checked %0d result items over %0d offset writes, %0d failures",
			result_cnt, cfg_writes, errors);
		if (errors == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule

### filelist.f
hdl/tpmc_pkg.sv
hdl/thruster_pair_mixer_calibrated_core.sv
verif/tb.sv
